// ----- rtl/core/dtcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dtcs_pkg: shared types and constants of the DDS tuning command sequencer
// Holds the request layout, the queued command descriptor, the opcodes and
// the fixed command words of the 28-bit DDS generator and the potentiometer.
// ----------------------------------------------------------------------------
package dtcs_pkg;

   // Request opcodes (carried on req_tuser)
   localparam logic [1:0] OP_SETUP     = 2'd0;
   localparam logic [1:0] OP_AMPLITUDE = 2'd1;
   localparam logic [1:0] OP_RAW       = 2'd2;

   // Waveform modes
   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [1:0] WAVE_SQUARE   = 2'd2;
   localparam logic [1:0] WAVE_NONE     = 2'd3;

   // Command words
   localparam logic [15:0] CMD_RESET     = 16'h0100;
   localparam logic [15:0] CMD_B28_RESET = 16'h2100;
   localparam logic [15:0] CMD_SINE      = 16'h2000;
   localparam logic [15:0] CMD_TRIANGLE  = 16'h2002;
   localparam logic [15:0] CMD_SQUARE    = 16'h2028;
   localparam logic [15:0] CMD_POT       = 16'h1100;
   localparam logic [15:0] TAG_REG0      = 16'h4000;
   localparam logic [15:0] TAG_REG1      = 16'h8000;
   localparam logic [15:0] TAG_PHASE     = 16'hC000;

   // Tuning scale register
   localparam int          SCALE_W     = 24;
   localparam logic [23:0] SCALE_RESET = 24'd10737418;

   // Tuning word arithmetic: product of 34-bit frequency and 24-bit scale,
   // divided by one billion through a reciprocal estimate from the top 32
   // product bits, which is low by at most one, then one remainder check.
   localparam int          FREQ_W     = 34;
   localparam int          FREQ_LO_W  = 17;
   localparam int          PART_W     = FREQ_LO_W + SCALE_W;
   localparam int          PROD_W     = FREQ_W + SCALE_W;
   localparam int          QUOT_W     = 29;
   localparam int          EST_LO     = 26;
   localparam int          EST_X_W    = PROD_W - EST_LO;
   localparam int          RECIP_W    = 30;
   // floor(2^59 / 1e9)
   localparam logic [29:0] RECIP_M    = 30'd576460752;
   localparam int          EST_W      = EST_X_W + RECIP_W;
   localparam int          EST_SHIFT  = 33;
   localparam int          REM_W      = 31;
   localparam logic [30:0] TW_DIVISOR = 31'd1000000000;
   localparam int          TW_W       = 28;
   localparam int          HALF_W     = 14;

   // Number of command words a setup can produce
   localparam int          MAX_WORDS  = 6;
   localparam int          STEP_W     = 3;

   // Request payload, last field in the low bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] raw_word;
      logic [7:0]  amplitude;
      logic [11:0] phase_value;
      logic [1:0]  wave_mode;
      logic [1:0]  freq_reg_select;
      logic [33:0] freq_millihertz;
   } req_data_type;

   // Command descriptor passed from the front end to the back end
   typedef struct packed {
      logic        is_setup;
      logic        device;
      logic [15:0] single_word;
      logic [27:0] tuning;
      logic [1:0]  freq_reg_select;
      logic [1:0]  wave_mode;
      logic [11:0] phase_value;
   } desc_type;

endpackage

// ----- rtl/core/dds_tuning_command_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// dds_tuning_command_sequencer_top: DDS and potentiometer command generator
// Turns waveform, amplitude and raw-write requests into 16-bit command words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per transfer; req_tuser holds the opcode.
//   rsp_* carries one command word per transfer; rsp_tuser selects the
//   device (0 DDS, 1 potentiometer) and rsp_tlast marks a request's final
//   word. csr_wr_en writes the 24-bit tuning scale; write it only when idle.
//   Amplitude and raw requests are taken one per cycle while req_tready is
//   high, and each word goes through the queue and the output register. A
//   waveform setup holds the intake through its multiply, add, reciprocal
//   estimate, remainder and queue write steps. Its words, up to six, follow
//   one per cycle while rsp_tready is high, and the intake takes requests
//   again after the queue write, while those words may still be in flight.
//   A queue of QUEUE_DEPTH descriptors lets the intake keep working while
//   the output stalls; when it fills, req_tready drops. Unknown opcodes are
//   taken and produce nothing. Reset empties the queue and output register,
//   and loads the tuning scale with its 25 MHz default.
// ----------------------------------------------------------------------------
module dds_tuning_command_sequencer_top import dtcs_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: freq_millihertz[33:0], freq_reg_select[35:34], wave_mode[37:36],
   //        phase_value[49:38], amplitude[57:50], raw_word[73:58], zero[79:74]
   input  logic [79:0] req_tdata,
   // tuser: op[1:0]
   input  logic [1:0]  req_tuser,
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: word[15:0]
   output logic [15:0] rsp_tdata,
   // tuser: device[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic [SCALE_W-1:0] tuning_scale_ff;
   req_data_type       req_data;
   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   desc_type           q_wr_desc;
   desc_type           q_head_desc;

   // Tuning scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         tuning_scale_ff <= csr_wr_data;
      end
   end

   assign req_data = req_data_type'(req_tdata);

   dtcs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .tuning_scale (tuning_scale_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_data     (req_data),
      .req_op       (req_tuser),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_desc       (q_wr_desc)
   );

   dtcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_wr_desc),
      .full      (q_full),
      .pop       (q_pop),
      .head_desc (q_head_desc),
      .empty     (q_empty)
   );

   dtcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (q_head_desc),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/dtcs_front.sv -----
// ----------------------------------------------------------------------------
// dtcs_front: request intake and tuning word computation
// Accepts requests, turns amplitude and raw writes into descriptors at once,
// and for a waveform setup computes floor(freq * scale / 1e9) with two
// partial-product multipliers, a reciprocal quotient estimate and a single
// remainder correction.
// ----------------------------------------------------------------------------
module dtcs_front import dtcs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [SCALE_W-1:0] tuning_scale,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  req_data_type       req_data,
   input  logic [1:0]         req_op,
   input  logic               q_full,
   output logic               q_push,
   output desc_type           q_desc
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_EST   = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_PUSH  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [FREQ_W-1:0]     freq_ff, freq_in;
   logic [1:0]            sel_ff, sel_in;
   logic [1:0]            mode_ff, mode_in;
   logic [11:0]           phase_ff, phase_in;
   logic [PART_W-1:0]     p_lo_ff, p_lo_in;
   logic [PART_W-1:0]     p_hi_ff, p_hi_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [PROD_W-1:0]     prod;
   logic [EST_W-1:0]      est;
   logic [REM_W-1:0]      back_prod;
   logic                  fix_up;
   logic [QUOT_W-1:0]     tuning;
   logic                  accept;
   logic                  is_single;
   desc_type              single_desc;
   desc_type              setup_desc;

   assign req_tready = (state_ff == ST_IDLE) && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign is_single  = (req_op == OP_AMPLITUDE) || (req_op == OP_RAW);

   // Full product from the two registered partial products
   assign prod = {{(PROD_W-PART_W){1'b0}}, p_lo_ff}
               + {p_hi_ff, {FREQ_LO_W{1'b0}}};

   // Quotient estimate from the top product bits; never high, at most one low
   assign est = EST_W'(prod_ff[PROD_W-1:EST_LO]) * EST_W'(RECIP_M);

   // Remainder is below 2e9, so 31 bits of modulo arithmetic are exact
   assign back_prod = REM_W'(quot_ff) * TW_DIVISOR;
   assign fix_up    = (rem_ff >= TW_DIVISOR);
   assign tuning    = quot_ff + {{(QUOT_W-1){1'b0}}, fix_up};

   // Descriptors
   always_comb begin
      single_desc = '0;
      if (req_op == OP_AMPLITUDE) begin
         single_desc.device      = 1'b1;
         single_desc.single_word = CMD_POT | {8'd0, req_data.amplitude};
      end else begin
         single_desc.device      = 1'b0;
         single_desc.single_word = req_data.raw_word;
      end

      setup_desc                 = '0;
      setup_desc.is_setup        = 1'b1;
      setup_desc.tuning          = tuning[TW_W-1:0];
      setup_desc.freq_reg_select = sel_ff;
      setup_desc.wave_mode       = mode_ff;
      setup_desc.phase_value     = phase_ff;
   end

   assign q_push = (accept && is_single) || ((state_ff == ST_PUSH) && !q_full);
   assign q_desc = (state_ff == ST_PUSH) ? setup_desc : single_desc;

   // Sequencer of the setup computation
   always_comb begin
      state_in = state_ff;
      freq_in  = freq_ff;
      sel_in   = sel_ff;
      mode_in  = mode_ff;
      phase_in = phase_ff;
      p_lo_in  = p_lo_ff;
      p_hi_in  = p_hi_ff;
      prod_in  = prod_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_SETUP)) begin
               freq_in  = req_data.freq_millihertz;
               sel_in   = req_data.freq_reg_select;
               mode_in  = req_data.wave_mode;
               phase_in = req_data.phase_value;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p_lo_in  = PART_W'(freq_ff[FREQ_LO_W-1:0]) * PART_W'(tuning_scale);
            p_hi_in  = PART_W'(freq_ff[FREQ_W-1:FREQ_LO_W]) * PART_W'(tuning_scale);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            prod_in  = prod;
            state_in = ST_EST;
         end
         ST_EST: begin
            quot_in  = est[EST_W-1:EST_SHIFT];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rem_in   = prod_ff[REM_W-1:0] - back_prod;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      freq_ff  <= freq_in;
      sel_ff   <= sel_in;
      mode_ff  <= mode_in;
      phase_ff <= phase_in;
      p_lo_ff  <= p_lo_in;
      p_hi_ff  <= p_hi_in;
      prod_ff  <= prod_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

endmodule

// ----- rtl/core/dtcs_queue.sv -----
// ----------------------------------------------------------------------------
// dtcs_queue: descriptor queue between front end and back end
// Small circular buffer of command descriptors; push and pop may happen in
// the same cycle. The writer checks full, the reader checks empty.
// ----------------------------------------------------------------------------
module dtcs_queue import dtcs_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output desc_type head_desc,
   output logic     empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign empty     = (cnt_ff == '0);
   assign head_desc = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ----- rtl/core/dtcs_back.sv -----
// ----------------------------------------------------------------------------
// dtcs_back: command word sequencer
// Expands the head descriptor into its command words, one per cycle unless
// stalled, skipping words that do not apply, and drives the output register.
// ----------------------------------------------------------------------------
module dtcs_back import dtcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  desc_type    head_desc,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic [15:0]          words [MAX_WORDS];
   logic [MAX_WORDS-1:0] mask;
   logic [15:0]          tag;
   logic [15:0]          wave_word;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [STEP_W-1:0]    nxt;
   logic                 more;
   logic                 load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_word_ff;
   logic                 rsp_device_ff;
   logic                 rsp_last_ff;

   // Waveform command
   always_comb begin
      unique case (head_desc.wave_mode)
         WAVE_SINE:     wave_word = CMD_SINE;
         WAVE_TRIANGLE: wave_word = CMD_TRIANGLE;
         WAVE_SQUARE:   wave_word = CMD_SQUARE;
         default:       wave_word = '0;
      endcase
   end

   assign tag = head_desc.freq_reg_select[0] ? TAG_REG1 : TAG_REG0;

   // Word list and presence mask of the head descriptor
   always_comb begin
      for (int i = 0; i < MAX_WORDS; i++) begin
         words[i] = '0;
      end
      if (head_desc.is_setup) begin
         words[0] = CMD_RESET;
         words[1] = CMD_B28_RESET;
         words[2] = tag | {2'b00, head_desc.tuning[HALF_W-1:0]};
         words[3] = tag | {2'b00, head_desc.tuning[TW_W-1:HALF_W]};
         words[4] = TAG_PHASE | {4'd0, head_desc.phase_value};
         words[5] = wave_word;
         mask = {head_desc.wave_mode != WAVE_NONE,
                 {3{!head_desc.freq_reg_select[1]}}, 2'b11};
      end else begin
         words[0] = head_desc.single_word;
         mask     = 6'b000001;
      end
   end

   // Next present word after the current step
   always_comb begin
      nxt  = '0;
      more = 1'b0;
      for (int i = MAX_WORDS - 1; i >= 0; i--) begin
         if (mask[i] && (STEP_W'(i) > step_ff)) begin
            nxt  = STEP_W'(i);
            more = 1'b1;
         end
      end
   end

   assign load  = !q_empty && (!rsp_valid_ff || rsp_tready);
   assign q_pop = load && !more;

   always_comb begin
      step_in = step_ff;
      if (load) begin
         step_in = more ? nxt : '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff   <= words[step_ff];
         rsp_device_ff <= !head_desc.is_setup && head_desc.device;
         rsp_last_ff   <= !more;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_device_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/core/dtcs_checker.sv -----
// ----------------------------------------------------------------------------
// dtcs_checker: port-level checks of the command sequencer
// Watches the result channel and the intake handshake over time.
// ----------------------------------------------------------------------------
module dtcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Out of reset: nothing pending, intake open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not clean after reset");

   // Potentiometer word is a single amplitude command
   a_pot_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[15:8] == 8'h11))
      else $error("bad potentiometer word");

endmodule

bind dds_tuning_command_sequencer_top dtcs_checker u_checker (.*);

// ----- bench/dds_tuning_command_sequencer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dds_tuning_command_sequencer_top_test: self-checking bench for the sequencer
// Drives waveform setups, amplitude sets, raw writes and unknown opcodes under
// several tuning scales and idle/stall profiles. A scoreboard predicts every
// command word from the accepted requests and checks the result stream in
// order, field by field.
// ----------------------------------------------------------------------------
module dds_tuning_command_sequencer_top_test;
   import dtcs_pkg::*;

   localparam logic [1:0]  OP_UNKNOWN     = 2'd3;
   localparam logic [1:0]  SEL_REG0       = 2'd0;
   localparam logic [1:0]  SEL_REG1       = 2'd1;
   localparam logic [63:0] TUNING_DIVISOR = 64'd1000000000;
   localparam logic [33:0] FREQ_TOP       = 34'd12500000000;
   localparam int          SETTLE_CYCLES  = 40;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          PHASE_ITEMS    = 72;

   // one command word as seen on the result channel
   typedef struct packed {
      logic [15:0] word;
      logic        device;
      logic        last;
   } cmd_word_type;

   // --------------------------------------------------------------------------
   // Scoreboard: predicts the command words of each request, checks in order
   // --------------------------------------------------------------------------
   class command_word_scoreboard;
      logic [23:0]  tuning_scale;
      cmd_word_type pending_words[$];
      int           errors;

      function new();
         tuning_scale = SCALE_RESET;
         errors       = 0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void note_request(logic [1:0] op, req_data_type req);
         cmd_word_type burst[$];
         logic [63:0]  tuning;
         logic [15:0]  tag;
         case (op)
            OP_SETUP: begin
               tuning = (64'(req.freq_millihertz) * 64'(tuning_scale)) / TUNING_DIVISOR;
               burst.push_back('{CMD_RESET, 1'b0, 1'b0});
               burst.push_back('{CMD_B28_RESET, 1'b0, 1'b0});
               // frequency and phase only for a valid register select
               if (req.freq_reg_select == SEL_REG0 || req.freq_reg_select == SEL_REG1) begin
                  tag = (req.freq_reg_select == SEL_REG0) ? TAG_REG0 : TAG_REG1;
                  burst.push_back('{{2'b00, tuning[13:0]} | tag, 1'b0, 1'b0});
                  burst.push_back('{{2'b00, tuning[27:14]} | tag, 1'b0, 1'b0});
                  burst.push_back('{{4'h0, req.phase_value} | TAG_PHASE, 1'b0, 1'b0});
               end
               case (req.wave_mode)
                  WAVE_SINE:     burst.push_back('{CMD_SINE, 1'b0, 1'b0});
                  WAVE_TRIANGLE: burst.push_back('{CMD_TRIANGLE, 1'b0, 1'b0});
                  WAVE_SQUARE:   burst.push_back('{CMD_SQUARE, 1'b0, 1'b0});
                  default: ;
               endcase
            end
            OP_AMPLITUDE: burst.push_back('{CMD_POT | {8'h00, req.amplitude}, 1'b1, 1'b0});
            OP_RAW:       burst.push_back('{req.raw_word, 1'b0, 1'b0});
            default: ;
         endcase
         if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i])
            pending_words.push_back(burst[i]);
      endfunction

      function void check_word(logic [15:0] word, logic device, logic last);
         cmd_word_type exp_w;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, actual %h device %0d last %0d",
                     $time, word, device, last);
            return;
         end
         exp_w = pending_words.pop_front();
         if (word !== exp_w.word) begin
            errors++;
            $display("%0t: word mismatch: expected %h, actual %h", $time, exp_w.word, word);
         end
         if (device !== exp_w.device) begin
            errors++;
            $display("%0t: device mismatch: expected %0d, actual %0d",
                     $time, exp_w.device, device);
         end
         if (last !== exp_w.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0d, actual %0d", $time, exp_w.last, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [23:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   command_word_scoreboard sb;

   dds_tuning_command_sequencer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor: record accepted transfers and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_data_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic logic [33:0] random_freq();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
         0: return r[33:0];
         1: return 34'(r % (64'(FREQ_TOP) + 64'd1));
         2: return 34'($urandom_range(0, 1 << 20));
         default: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return FREQ_TOP;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   // all fields random; callers override what the case needs
   function automatic req_data_type random_fields();
      req_data_type d;
      d.pad             = '0;
      d.raw_word        = 16'($urandom());
      d.amplitude       = 8'($urandom());
      d.phase_value     = 12'($urandom());
      d.wave_mode       = 2'($urandom());
      d.freq_reg_select = 2'($urandom());
      d.freq_millihertz = random_freq();
      return d;
   endfunction

   // one request transfer; entered and left just after a falling edge
   task automatic send_request(input logic [1:0] op, input req_data_type d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = d;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_words_drained();
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // only called with the block idle
   task automatic write_tuning_scale(input logic [23:0] value);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.tuning_scale = value;
   endtask

   task automatic send_setup(input logic [33:0] freq, input logic [1:0] sel,
                             input logic [1:0] mode, input logic [11:0] phase);
      req_data_type d;
      d                 = random_fields();
      d.freq_millihertz = freq;
      d.freq_reg_select = sel;
      d.wave_mode       = mode;
      d.phase_value     = phase;
      send_request(OP_SETUP, d);
   endtask

   task automatic send_amplitude(input logic [7:0] amp);
      req_data_type d;
      d           = random_fields();
      d.amplitude = amp;
      send_request(OP_AMPLITUDE, d);
   endtask

   task automatic send_raw(input logic [15:0] raw);
      req_data_type d;
      d          = random_fields();
      d.raw_word = raw;
      send_request(OP_RAW, d);
   endtask

   // field extremes, every opcode and the skip cases
   task automatic run_directed();
      send_setup('0, SEL_REG0, WAVE_SINE, 12'h000);
      send_setup(FREQ_TOP, SEL_REG1, WAVE_TRIANGLE, 12'hFFF);
      send_setup('1, SEL_REG0, WAVE_SQUARE, 12'hAAA);
      send_setup(34'h2AAAAAAAA, SEL_REG1, WAVE_SINE, 12'h555);
      send_setup(34'h155555555, SEL_REG0, WAVE_TRIANGLE, 12'h123);
      send_setup(34'd1000000000, 2'd2, WAVE_SINE, 12'hFFF);
      send_setup(34'd1000000000, 2'd3, WAVE_SQUARE, 12'hFFF);
      send_setup(34'd440000, SEL_REG0, WAVE_NONE, 12'h800);
      send_setup(34'd440000, 2'd3, WAVE_NONE, 12'h001);
      send_amplitude(8'h00);
      send_amplitude(8'hFF);
      send_amplitude(8'hAA);
      send_amplitude(8'h55);
      send_raw(16'h0000);
      send_raw(16'hFFFF);
      send_raw(16'hAAAA);
      send_raw(16'h5555);
      send_request(OP_UNKNOWN, random_fields());
      send_raw(16'h2100);
      send_request(OP_UNKNOWN, '0);
      send_amplitude(8'h01);
   endtask

   task automatic run_random(input int items, input bit drain_midway);
      req_data_type d;
      int           counted;
      int           pick;
      counted = 0;
      while (counted < items) begin
         d    = random_fields();
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // mostly well-formed register selects
            if ($urandom_range(0, 99) < 80)
               d.freq_reg_select = 2'($urandom_range(0, 1));
            send_request(OP_SETUP, d);
            counted++;
         end else if (pick < 70) begin
            send_request(OP_AMPLITUDE, d);
            counted++;
         end else if (pick < 92) begin
            send_request(OP_RAW, d);
            counted++;
         end else begin
            send_request(OP_UNKNOWN, d);
         end
         // sender holds off until the result stream is empty
         if (drain_midway && counted == items / 2)
            wait_for_words_drained();
      end
   endtask

   initial begin
      logic [23:0] scales [5];
      int          send_profile [5];
      int          recv_profile [5];
      sb             = new();
      clock          = 1'b0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = OP_SETUP;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      scales         = '{SCALE_RESET, 24'd0, 24'hFFFFFF, 24'($urandom_range(1, 24'hFFFFFE)),
                         24'd1};
      send_profile   = '{0, 85, 0, 9, 0};
      recv_profile   = '{0, 0, 85, 9, 0};

      repeat (6) @(negedge clock);
      reset = 1'b0;

      write_tuning_scale(SCALE_RESET);
      run_directed();

      // one phase per scale and idle profile
      for (int p = 0; p < 5; p++) begin
         wait_for_words_drained();
         write_tuning_scale(scales[p]);
         send_idle_pct  = send_profile[p];
         recv_stall_pct = recv_profile[p];
         // tuning word past 28 bits at the largest scales
         send_setup('1, 2'($urandom_range(0, 1)), 2'($urandom()), 12'($urandom()));
         run_random(PHASE_ITEMS, p == 0 || p == 2);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_for_words_drained();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/dtcs_pkg.sv
rtl/core/dtcs_front.sv
rtl/core/dtcs_queue.sv
rtl/core/dtcs_back.sv
rtl/core/dds_tuning_command_sequencer_top.sv
rtl/core/dtcs_checker.sv
bench/dds_tuning_command_sequencer_top_test.sv
